/* hw/rtl/uap_pkg.sv */
// Shared types and constants for the URL authority parser.
// Depends on nothing; used by uap_port_acc and url_authority_parser.
`timescale 1ns / 1ps

package uap_pkg;

    // Character codes that the parser looks for.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [15:0] PORT_MAX = 16'hFFFF;

    typedef logic [11:0] t_len12;
    typedef logic [12:0] t_len13;

    typedef enum logic [2:0] {
        PH_SCHEME     = 3'd0,
        PH_SLASH1     = 3'd1,
        PH_SLASH2     = 3'd2,
        PH_HOST       = 3'd3,
        PH_PORT_FIRST = 3'd4,
        PH_PORT       = 3'd5,
        PH_PATH       = 3'd6,
        PH_DONE       = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_COLON   = 3'd1,
        ST_LEAD_COLON = 3'd2,
        ST_NO_SLASHES = 3'd3,
        ST_EMPTY_HOST = 3'd4,
        ST_BAD_PORT   = 3'd5,
        ST_PORT_SLASH = 3'd6,
        ST_TOO_LONG   = 3'd7
    } t_status;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       nul_terminated;
    } t_request;

    typedef struct packed {
        t_status    status;
        t_len12     scheme_size;
        t_len12     host_offset;
        t_len12     host_size;
        logic [15:0] port_number;
        t_len13     port_size;
        t_len13     path_offset;
        t_len13     path_size;
        logic       port_saturated;
    } t_result;

endpackage

/* hw/rtl/uap_port_acc.sv */
// Decimal port accumulator: multiplies by ten, adds one digit and saturates.
// Depends on uap_pkg for the character and saturation constants.
`timescale 1ns / 1ps

module uap_port_acc (
    input  logic [15:0] i_accum,
    input  logic [7:0]  i_ch,
    output logic [15:0] o_accum,
    output logic        o_saturated
);

    logic [19:0] times_ten;
    logic [19:0] sum;
    logic [3:0]  digit;

    // Ten times the value as two shifted copies; the sum never passes 20 bits.
    assign times_ten   = {1'b0, i_accum, 3'b000} + {3'b000, i_accum, 1'b0};
    assign digit       = 4'(i_ch - uap_pkg::CH_ZERO);
    assign sum         = times_ten + {16'd0, digit};
    assign o_saturated = |sum[19:16];
    assign o_accum     = o_saturated ? uap_pkg::PORT_MAX : sum[15:0];

endmodule

/* hw/rtl/url_authority_parser.sv */
// Top level of the URL authority parser: byte-stream splitter for
// scheme://host[:port][/path]. Depends on uap_pkg and uap_port_acc.
`timescale 1ns / 1ps

// How to use this block
// ---------------------
// The input channel (i_in_valid, o_in_stall, i_in) carries one request per
// URL byte, first byte first; i_in.last marks the final byte of a string and
// i_in.nul_terminated is taken with that final byte. The output channel
// (o_out_valid, i_out_stall, o_out) carries one result per string: a status,
// the field offsets and lengths, and the decoded port.
// A request is taken into an input register, the parse state and the result
// are worked out from it combinationally, and the result register is loaded
// from them as a final byte leaves the input register. One byte is accepted
// in every cycle while no final byte waits there for the result slot; the
// parse state registers, updated once per byte, set that figure.
// When the receiver stalls and a finished result is waiting, further bytes
// that do not end a string keep flowing; only a byte that ends a string holds
// in the input register (and o_in_stall rises) until the result slot frees.
// After the result is formed the parse state returns to its reset values,
// ready for the next string. Synchronous reset (i_rst_n low) empties both
// registers and puts the parser in the scheme phase with all counters zero.
// Strings longer than MAX_LEN bytes report status 7 with every other field 0.

module url_authority_parser #(
    parameter int MAX_LEN = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  uap_pkg::t_request i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output uap_pkg::t_result  o_out
);

    // Byte positions run from 0 up to MAX_LEN inclusive.
    localparam int PW = $clog2(MAX_LEN + 1);
    localparam logic [PW-1:0] MaxPos = PW'(MAX_LEN);

    // Input register.
    logic              r_in_valid;
    uap_pkg::t_request r_in;

    // Parse state.
    uap_pkg::t_phase  r_phase, n_phase;
    logic [PW-1:0]    r_pos, n_pos;
    logic [PW-1:0]    r_scheme_len, n_scheme_len;
    logic [PW-1:0]    r_host_start, n_host_start;
    logic [PW-1:0]    r_host_len, n_host_len;
    logic [15:0]      r_port_accum, n_port_accum;
    logic [PW-1:0]    r_port_len, n_port_len;
    logic [PW-1:0]    r_path_start, n_path_start;
    uap_pkg::t_status r_error, n_error;
    logic             r_port_sat, n_port_sat;
    logic             r_too_long, n_too_long;

    // Output register.
    logic             r_out_valid;
    uap_pkg::t_result r_out;
    uap_pkg::t_result n_out;

    logic             out_free;
    logic             fire;
    logic             is_digit;
    logic [15:0]      acc_next;
    logic             acc_sat;
    uap_pkg::t_status status;
    logic [PW-1:0]    path_len;
    logic [PW-1:0]    host_off;

    // A byte that ends a string needs the result slot; other bytes never wait.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && (!r_in.last || out_free);
    assign o_in_stall = r_in_valid && !fire;

    assign is_digit = (r_in.ch >= uap_pkg::CH_ZERO) && (r_in.ch <= uap_pkg::CH_NINE);

    uap_port_acc u_port_acc (
        .i_accum     (r_port_accum),
        .i_ch        (r_in.ch),
        .o_accum     (acc_next),
        .o_saturated (acc_sat)
    );

    // Next parse state for the byte held in the input register.
    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_scheme_len = r_scheme_len;
        n_host_start = r_host_start;
        n_host_len   = r_host_len;
        n_port_accum = r_port_accum;
        n_port_len   = r_port_len;
        n_path_start = r_path_start;
        n_error      = r_error;
        n_port_sat   = r_port_sat;
        n_too_long   = r_too_long;

        if (r_pos == MaxPos) begin
            // The position holds at the limit; any further byte is too many.
            n_too_long = 1'b1;
        end else begin
            n_pos = r_pos + PW'(1);
            case (r_phase)
                uap_pkg::PH_SCHEME: begin
                    if (r_in.ch == uap_pkg::CH_NUL) begin
                        n_error = uap_pkg::ST_NO_COLON;
                        n_phase = uap_pkg::PH_DONE;
                    end else if (r_in.ch == uap_pkg::CH_COLON) begin
                        if (r_pos == '0) begin
                            n_error = uap_pkg::ST_LEAD_COLON;
                            n_phase = uap_pkg::PH_DONE;
                        end else begin
                            n_scheme_len = r_pos;
                            n_phase      = uap_pkg::PH_SLASH1;
                        end
                    end
                end
                uap_pkg::PH_SLASH1: begin
                    if (r_in.ch == uap_pkg::CH_SLASH) begin
                        n_phase = uap_pkg::PH_SLASH2;
                    end else begin
                        n_error = uap_pkg::ST_NO_SLASHES;
                        n_phase = uap_pkg::PH_DONE;
                    end
                end
                uap_pkg::PH_SLASH2: begin
                    if (r_in.ch == uap_pkg::CH_SLASH) begin
                        n_host_start = r_pos + PW'(1);
                        n_phase      = uap_pkg::PH_HOST;
                    end else begin
                        n_error = uap_pkg::ST_NO_SLASHES;
                        n_phase = uap_pkg::PH_DONE;
                    end
                end
                uap_pkg::PH_HOST: begin
                    if (r_in.ch == uap_pkg::CH_NUL || r_in.ch == uap_pkg::CH_COLON ||
                        r_in.ch == uap_pkg::CH_SLASH) begin
                        if (r_host_len == '0) begin
                            n_error = uap_pkg::ST_EMPTY_HOST;
                            n_phase = uap_pkg::PH_DONE;
                        end else if (r_in.ch == uap_pkg::CH_NUL) begin
                            n_error = uap_pkg::ST_OK;
                            n_phase = uap_pkg::PH_DONE;
                        end else if (r_in.ch == uap_pkg::CH_COLON) begin
                            n_phase = uap_pkg::PH_PORT_FIRST;
                        end else begin
                            n_path_start = r_pos + PW'(1);
                            n_phase      = uap_pkg::PH_PATH;
                        end
                    end else begin
                        n_host_len = r_host_len + PW'(1);
                    end
                end
                uap_pkg::PH_PORT_FIRST: begin
                    if (is_digit) begin
                        n_port_accum = acc_next;
                        n_port_sat   = r_port_sat | acc_sat;
                        n_port_len   = PW'(2);
                        n_phase      = uap_pkg::PH_PORT;
                    end else begin
                        n_error = uap_pkg::ST_BAD_PORT;
                        n_phase = uap_pkg::PH_DONE;
                    end
                end
                uap_pkg::PH_PORT: begin
                    if (is_digit) begin
                        n_port_accum = acc_next;
                        n_port_sat   = r_port_sat | acc_sat;
                        n_port_len   = r_port_len + PW'(1);
                    end else if (r_in.ch == uap_pkg::CH_NUL) begin
                        n_error = uap_pkg::ST_OK;
                        n_phase = uap_pkg::PH_DONE;
                    end else if (r_in.ch == uap_pkg::CH_SLASH) begin
                        n_path_start = r_pos + PW'(1);
                        n_phase      = uap_pkg::PH_PATH;
                    end else begin
                        n_error = uap_pkg::ST_PORT_SLASH;
                        n_phase = uap_pkg::PH_DONE;
                    end
                end
                default: begin
                    // Path bytes and anything after an early finish are not checked.
                end
            endcase
        end
    end

    // Result built from the state as it stands after the final byte.
    always_comb begin
        path_len = '0;
        case (n_phase)
            uap_pkg::PH_SCHEME:     status = uap_pkg::ST_NO_COLON;
            uap_pkg::PH_SLASH1:     status = uap_pkg::ST_NO_SLASHES;
            uap_pkg::PH_SLASH2:     status = uap_pkg::ST_NO_SLASHES;
            uap_pkg::PH_HOST:       status = (n_host_len == '0) ? uap_pkg::ST_EMPTY_HOST
                                                                : uap_pkg::ST_OK;
            uap_pkg::PH_PORT_FIRST: status = uap_pkg::ST_BAD_PORT;
            uap_pkg::PH_PORT:       status = uap_pkg::ST_OK;
            uap_pkg::PH_PATH: begin
                status = uap_pkg::ST_OK;
                if (!r_in.nul_terminated) begin
                    path_len = n_pos - n_path_start;
                end
            end
            default:                status = n_error;
        endcase

        host_off = (n_host_len != '0) ? n_host_start : '0;

        n_out = '0;
        if (n_too_long) begin
            n_out.status = uap_pkg::ST_TOO_LONG;
        end else begin
            n_out.status         = status;
            n_out.scheme_size    = uap_pkg::t_len12'(n_scheme_len);
            n_out.host_offset    = uap_pkg::t_len12'(host_off);
            n_out.host_size      = uap_pkg::t_len12'(n_host_len);
            n_out.port_number    = n_port_accum;
            n_out.port_size      = uap_pkg::t_len13'(n_port_len);
            n_out.path_offset    = uap_pkg::t_len13'(n_path_start);
            n_out.path_size      = uap_pkg::t_len13'(path_len);
            n_out.port_saturated = n_port_sat;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // Parse state: cleared after each string so the next one starts afresh.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && r_in.last)) begin
            r_phase      <= uap_pkg::PH_SCHEME;
            r_pos        <= '0;
            r_scheme_len <= '0;
            r_host_start <= '0;
            r_host_len   <= '0;
            r_port_accum <= '0;
            r_port_len   <= '0;
            r_path_start <= '0;
            r_error      <= uap_pkg::ST_OK;
            r_port_sat   <= 1'b0;
            r_too_long   <= 1'b0;
        end else if (fire) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_scheme_len <= n_scheme_len;
            r_host_start <= n_host_start;
            r_host_len   <= n_host_len;
            r_port_accum <= n_port_accum;
            r_port_len   <= n_port_len;
            r_path_start <= n_path_start;
            r_error      <= n_error;
            r_port_sat   <= n_port_sat;
            r_too_long   <= n_too_long;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_in.last) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* tb/sv/uap_tb_pkg.sv */
// Expected-result tracking for the URL authority parser testbench.
// Depends on uap_pkg for the request, result, phase and status types.
`timescale 1ns / 1ps

package uap_tb_pkg;

    class url_split_ledger;

        int               max_len;
        int               failures;
        int               status_hits[8];
        uap_pkg::t_result pending_splits[$];

        // Parse state, a copy of what the block keeps for the current string.
        uap_pkg::t_phase  stage;
        logic [12:0]      taken;
        logic [12:0]      scheme_end;
        logic [12:0]      host_first;
        logic [12:0]      host_bytes;
        logic [15:0]      port_value;
        logic [12:0]      port_chars;
        logic [12:0]      path_first;
        uap_pkg::t_status stop_code;
        logic             port_clipped;
        logic             overrun;

        function new(int limit);
            max_len  = limit;
            failures = 0;
            clear();
        endfunction

        function void clear();
            stage        = uap_pkg::PH_SCHEME;
            taken        = '0;
            scheme_end   = '0;
            host_first   = '0;
            host_bytes   = '0;
            port_value   = '0;
            port_chars   = '0;
            path_first   = '0;
            stop_code    = uap_pkg::ST_OK;
            port_clipped = 1'b0;
            overrun      = 1'b0;
        endfunction

        function int outstanding();
            return pending_splits.size();
        endfunction

        function void halt_with(uap_pkg::t_status code);
            stop_code = code;
            stage     = uap_pkg::PH_DONE;
        endfunction

        function bit is_digit(logic [7:0] ch);
            return ch >= uap_pkg::CH_ZERO && ch <= uap_pkg::CH_NINE;
        endfunction

        function void add_digit(logic [7:0] ch);
            int v;
            v = int'(port_value) * 10 + int'(ch - uap_pkg::CH_ZERO);
            if (v > int'(uap_pkg::PORT_MAX)) begin
                v = int'(uap_pkg::PORT_MAX);
                port_clipped = 1'b1;
            end
            port_value = 16'(v);
        endfunction

        // Advance the parse by one accepted byte and, on the final byte of a
        // string, queue the result the block must give for it.
        function void note_byte(uap_pkg::t_request r);
            logic [12:0]      at;
            uap_pkg::t_result want;
            at = taken;
            if (int'(at) >= max_len) begin
                overrun = 1'b1;
            end else begin
                case (stage)
                    uap_pkg::PH_SCHEME: begin
                        if (r.ch == uap_pkg::CH_NUL) begin
                            halt_with(uap_pkg::ST_NO_COLON);
                        end else if (r.ch == uap_pkg::CH_COLON) begin
                            if (at == 13'd0) begin
                                halt_with(uap_pkg::ST_LEAD_COLON);
                            end else begin
                                scheme_end = at;
                                stage      = uap_pkg::PH_SLASH1;
                            end
                        end
                    end
                    uap_pkg::PH_SLASH1: begin
                        if (r.ch == uap_pkg::CH_SLASH) stage = uap_pkg::PH_SLASH2;
                        else halt_with(uap_pkg::ST_NO_SLASHES);
                    end
                    uap_pkg::PH_SLASH2: begin
                        if (r.ch == uap_pkg::CH_SLASH) begin
                            host_first = at + 13'd1;
                            stage      = uap_pkg::PH_HOST;
                        end else begin
                            halt_with(uap_pkg::ST_NO_SLASHES);
                        end
                    end
                    uap_pkg::PH_HOST: begin
                        if (r.ch == uap_pkg::CH_NUL || r.ch == uap_pkg::CH_COLON ||
                            r.ch == uap_pkg::CH_SLASH) begin
                            if (host_bytes == 13'd0) begin
                                halt_with(uap_pkg::ST_EMPTY_HOST);
                            end else if (r.ch == uap_pkg::CH_NUL) begin
                                halt_with(uap_pkg::ST_OK);
                            end else if (r.ch == uap_pkg::CH_COLON) begin
                                stage = uap_pkg::PH_PORT_FIRST;
                            end else begin
                                path_first = at + 13'd1;
                                stage      = uap_pkg::PH_PATH;
                            end
                        end else begin
                            host_bytes++;
                        end
                    end
                    uap_pkg::PH_PORT_FIRST: begin
                        if (is_digit(r.ch)) begin
                            add_digit(r.ch);
                            port_chars = 13'd2;
                            stage      = uap_pkg::PH_PORT;
                        end else begin
                            halt_with(uap_pkg::ST_BAD_PORT);
                        end
                    end
                    uap_pkg::PH_PORT: begin
                        if (is_digit(r.ch)) begin
                            add_digit(r.ch);
                            port_chars++;
                        end else if (r.ch == uap_pkg::CH_NUL) begin
                            halt_with(uap_pkg::ST_OK);
                        end else if (r.ch == uap_pkg::CH_SLASH) begin
                            path_first = at + 13'd1;
                            stage      = uap_pkg::PH_PATH;
                        end else begin
                            halt_with(uap_pkg::ST_PORT_SLASH);
                        end
                    end
                    default: ;
                endcase
                taken = at + 13'd1;
            end

            if (!r.last) return;

            want = '0;
            if (overrun) begin
                want.status = uap_pkg::ST_TOO_LONG;
            end else begin
                case (stage)
                    uap_pkg::PH_SCHEME:     want.status = uap_pkg::ST_NO_COLON;
                    uap_pkg::PH_SLASH1,
                    uap_pkg::PH_SLASH2:     want.status = uap_pkg::ST_NO_SLASHES;
                    uap_pkg::PH_HOST: begin
                        want.status = (host_bytes == 13'd0) ? uap_pkg::ST_EMPTY_HOST
                                                            : uap_pkg::ST_OK;
                    end
                    uap_pkg::PH_PORT_FIRST: want.status = uap_pkg::ST_BAD_PORT;
                    uap_pkg::PH_PORT:       want.status = uap_pkg::ST_OK;
                    uap_pkg::PH_PATH: begin
                        want.status = uap_pkg::ST_OK;
                        if (!r.nul_terminated) want.path_size = taken - path_first;
                    end
                    default:                want.status = stop_code;
                endcase
                want.scheme_size    = scheme_end[11:0];
                want.host_offset    = (host_bytes != 13'd0) ? host_first[11:0] : 12'd0;
                want.host_size      = host_bytes[11:0];
                want.port_number    = port_value;
                want.port_size      = port_chars;
                want.path_offset    = path_first;
                want.port_saturated = port_clipped;
            end
            pending_splits.push_back(want);
            status_hits[want.status]++;
            clear();
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                failures++;
            end
        endfunction

        function void check_split(uap_pkg::t_result got);
            uap_pkg::t_result want;
            if (pending_splits.size() == 0) begin
                $error("result with no string outstanding: status %0d", got.status);
                failures++;
                return;
            end
            want = pending_splits.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("scheme_size", 32'(want.scheme_size), 32'(got.scheme_size));
            compare_field("host_offset", 32'(want.host_offset), 32'(got.host_offset));
            compare_field("host_size", 32'(want.host_size), 32'(got.host_size));
            compare_field("port_number", 32'(want.port_number), 32'(got.port_number));
            compare_field("port_size", 32'(want.port_size), 32'(got.port_size));
            compare_field("path_offset", 32'(want.path_offset), 32'(got.path_offset));
            compare_field("path_size", 32'(want.path_size), 32'(got.path_size));
            compare_field("port_saturated", 32'(want.port_saturated),
                          32'(got.port_saturated));
        endfunction

    endclass

endpackage

/* tb/sv/tb_url_authority_parser.sv */
// Self-checking testbench for url_authority_parser: streams URL strings byte
// by byte and checks each parse result. Depends on uap_pkg and uap_tb_pkg.
`timescale 1ns / 1ps

module tb_url_authority_parser;

    localparam int MAX_LEN         = 4096;
    // Bytes of random strings to send after the directed ones.
    localparam int RANDOM_ITEMS    = 770;
    // A correct run never goes this many cycles without a request or a
    // result moving: the worst is a sender gap, a receiver stall and the
    // pass through the block's registers, which together stay well below it.
    localparam int WATCHDOG_CYCLES = 1000;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    uap_pkg::t_request in_req    = '0;
    logic              in_stall;
    logic              out_valid;
    logic              out_stall = 1'b0;
    uap_pkg::t_result  out_res;

    // Whether the sender and receiver insert random waits; switched per
    // string so that there are stretches running flat out as well.
    bit tx_idle_on;
    bit rx_idle_on = 1'b0;

    int items_sent   = 0;
    int results_seen = 0;

    logic [7:0]                  url_bytes[$];
    uap_tb_pkg::url_split_ledger ledger;

    url_authority_parser #(
        .MAX_LEN(MAX_LEN)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_res)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Drive one request and hold it until the block takes it. Valid is left
    // high on acceptance, so that back-to-back requests never lower and raise
    // it within the same time step; the next call lowers it if it wants a gap.
    task automatic send_byte(input uap_pkg::t_request r);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 14) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        ledger.note_byte(r);
        items_sent++;
    endtask

    // Send the bytes held in url_bytes as one string. The NUL-terminated flag
    // only counts on the final byte, so on the others it is left random.
    task automatic send_url(input bit nul_mode);
        uap_pkg::t_request r;
        foreach (url_bytes[i]) begin
            r.ch             = url_bytes[i];
            r.last           = (i == url_bytes.size() - 1);
            r.nul_terminated = r.last ? nul_mode : 1'($urandom_range(0, 1));
            send_byte(r);
        end
    endtask

    // Drop valid and wait until every outstanding result has come back. The
    // count is looked at on falling edges, clear of the receiver's updates.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (ledger.outstanding() != 0);
        @(posedge clk);
    endtask

    function automatic void load_text(input string s);
        foreach (s[i]) url_bytes.push_back(s[i]);
    endfunction

    // Bytes biased towards the characters that steer the parser.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 5))
            0:       return uap_pkg::CH_NUL;
            1:       return uap_pkg::CH_COLON;
            2:       return uap_pkg::CH_SLASH;
            3:       return uap_pkg::CH_ZERO + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] scheme_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == uap_pkg::CH_NUL || b == uap_pkg::CH_COLON);
        return b;
    endfunction

    function automatic logic [7:0] host_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == uap_pkg::CH_NUL || b == uap_pkg::CH_COLON || b == uap_pkg::CH_SLASH);
        return b;
    endfunction

    // Mostly well-formed scheme://host[:port][/path] strings with random
    // content, so that the parse reaches the port and path phases; the rest
    // are raw noise or a well-formed string broken at one byte or cut short.
    function automatic void build_url();
        int shape;
        int spot;
        url_bytes = {};
        shape = $urandom_range(0, 99);
        if (shape < 8) begin
            repeat ($urandom_range(1, 12)) url_bytes.push_back(noise_byte());
            return;
        end
        if ($urandom_range(0, 19) != 0)
            repeat ($urandom_range(1, 6)) url_bytes.push_back(scheme_byte());
        load_text("://");
        if ($urandom_range(0, 14) != 0)
            repeat ($urandom_range(1, 8)) url_bytes.push_back(host_byte());
        if ($urandom_range(0, 1) == 1) begin
            url_bytes.push_back(uap_pkg::CH_COLON);
            // Five digits or more often run past 65535 and saturate.
            if ($urandom_range(0, 19) != 0)
                repeat ($urandom_range(1, 7))
                    url_bytes.push_back(uap_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 9) < 6) begin
            url_bytes.push_back(uap_pkg::CH_SLASH);
            repeat ($urandom_range(0, 10)) url_bytes.push_back(noise_byte());
        end
        if ($urandom_range(0, 3) == 0) url_bytes.push_back(uap_pkg::CH_NUL);
        if (shape < 25) begin
            spot = $urandom_range(0, url_bytes.size() - 1);
            case ($urandom_range(0, 2))
                0: url_bytes[spot] = noise_byte();
                1: if (url_bytes.size() > 1) url_bytes.delete(spot);
                default: while (url_bytes.size() > spot + 1) void'(url_bytes.pop_back());
            endcase
        end
    endfunction

    // Receiver: takes results, draws a stall for the next one, and hands
    // each result to the ledger to be checked.
    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                ledger.check_split(out_res);
                results_seen++;
                hold = rx_idle_on ? $urandom_range(0, 14) : 0;
            end else if (out_valid && hold != 0) begin
                hold--;
            end
            out_stall <= (hold != 0);
        end
    end

    // Ends the run if neither a request nor a result moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
            else quiet++;
        end
        $display("Watchdog: no request or result moved for %0d cycles.", WATCHDOG_CYCLES);
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int random_items;
        int strings;

        ledger       = new(MAX_LEN);
        random_items = 0;
        strings      = 0;
        tx_idle_on   = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed strings, one per error status but too long. A NUL in the scheme ends
        // parsing, so the colon after it must be ignored; a string that
        // stops after one slash still reports the missing slashes; an empty
        // host before a slash; a colon with no digit at the end of the
        // string; and a port followed by something other than a slash.
        url_bytes = {uap_pkg::CH_NUL, uap_pkg::CH_COLON};
        send_url(1'b1);
        url_bytes = {uap_pkg::CH_COLON};
        send_url(1'b0);
        url_bytes = {};
        load_text("a:/");
        send_url(1'b0);
        url_bytes = {};
        load_text("a:///");
        send_url(1'b1);
        url_bytes = {};
        load_text("a://b:");
        send_url(1'b0);
        url_bytes = {};
        load_text("a://b:1x");
        send_url(1'b0);
        drain_results();

        // Random strings until the byte budget is spent.
        while (random_items < RANDOM_ITEMS) begin
            strings++;
            rx_idle_on <= ($urandom_range(0, 3) != 0);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            build_url();
            random_items += url_bytes.size();
            send_url(1'($urandom_range(0, 1)));
            // Now and then let the block empty completely before going on.
            if (strings % 25 == 0) drain_results();
        end

        drain_results();
        repeat (8) @(posedge clk);

        $display("Sent %0d URL strings in %0d bytes; %0d results checked.",
                 strings + 6, items_sent, results_seen);
        $display("Results by status code 0 to 7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 ledger.status_hits[0], ledger.status_hits[1], ledger.status_hits[2],
                 ledger.status_hits[3], ledger.status_hits[4], ledger.status_hits[5],
                 ledger.status_hits[6], ledger.status_hits[7]);
        if (ledger.failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
